/* src/tdf_pkg.sv */
`default_nettype none
package tdf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;

    // Which value goes out on an emitted item.
    typedef enum logic [1:0] {
        SEL_NOFAC = 2'd0,
        SEL_TWO   = 2'd1,
        SEL_CAND  = 2'd2,
        SEL_REM   = 2'd3
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      shift;
        logic      div_start;
        logic      take_quot;
        logic      cand_inc;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
    } cmd_t;

    typedef struct packed {
        logic value_le1;
        logic rem_even;
        logic rem_is_two;
        logic div_done;
        logic cand_gt_q;
        logic mod_zero;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

/* src/tdf_div.sv */
`default_nettype none
module tdf_div
    import tdf_pkg::*;
#(
    parameter int W  = VALUE_WIDTH_DEF,
    parameter int CW = VALUE_WIDTH_DEF / 2 + 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [W-1:0]  dividend,
    input  wire logic [CW-1:0] divisor,
    output logic               done,
    output logic [W-1:0]       quot,
    output logic [CW-1:0]      rmd
);

    localparam int CNTW = (W > 1) ? $clog2(W) : 1;

    logic [CW-1:0]   p_reg, p_next;
    logic [W-1:0]    q_reg, q_next;
    logic [CW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [CW:0] shifted;
    logic [CW:0] diff;
    logic        ge;

    // restoring step: one quotient bit per cycle
    always_comb
    begin
        shifted = {p_reg, q_reg[W-1]};
        diff    = shifted - {1'b0, d_reg};
        ge      = (shifted >= {1'b0, d_reg});
        p_next  = ge ? diff[CW-1:0] : shifted[CW-1:0];
        q_next  = {q_reg[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= '0;
            q_reg <= dividend;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
            q_reg <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rmd  = p_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule
`default_nettype wire

/* src/tdf_dp.sv */
`default_nettype none
module tdf_dp
    import tdf_pkg::*;
#(
    parameter int W = VALUE_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic [FIELD_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [FIELD_W-1:0]      factor,
    output logic                    last_factor,
    output logic                    status
);

    localparam int CW = W / 2 + 1;

    logic [W-1:0]  rem_reg;
    logic [CW-1:0] cand_reg;
    logic [W-1:0]  quot;
    logic [CW-1:0] rmd;
    logic          div_done;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] factor_reg, factor_next;
    logic               last_reg;
    logic               status_reg;

    tdf_div #(.W(W), .CW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rem_reg),
        .divisor  (cand_reg),
        .done     (div_done),
        .quot     (quot),
        .rmd      (rmd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            cand_reg <= CW'(3);
        end
        else
        begin
            if (cmd.load)
            begin
                rem_reg  <= W'(value);
                cand_reg <= CW'(3);
            end
            else if (cmd.shift)
                rem_reg <= rem_reg >> 1;
            else if (cmd.take_quot)
                rem_reg <= quot;
            if (cmd.cand_inc)
                cand_reg <= cand_reg + CW'(2);
        end
    end

    always_comb
    begin
        unique case (cmd.emit_sel)
            SEL_NOFAC: factor_next = '0;
            SEL_TWO:   factor_next = FIELD_W'(2);
            SEL_CAND:  factor_next = FIELD_W'(cand_reg);
            SEL_REM:   factor_next = FIELD_W'(rem_reg);
            default:   factor_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            factor_reg <= factor_next;
            last_reg   <= cmd.emit_last;
            status_reg <= (cmd.emit_sel == SEL_NOFAC);
        end
    end

    always_comb
    begin
        stat.value_le1  = (rem_reg <= W'(1));
        stat.rem_even   = ~rem_reg[0];
        stat.rem_is_two = (rem_reg == W'(2));
        stat.div_done   = div_done;
        stat.cand_gt_q  = (W'(cand_reg) > quot);
        stat.mod_zero   = (rmd == '0);
        stat.out_free   = ~out_valid_reg | ~out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign factor      = factor_reg;
    assign last_factor = last_reg;
    assign status      = status_reg;

    a_odd_dividend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> rem_reg[0])
        else $error("division started on an even remainder");

    a_odd_cand: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg[0])
        else $error("trial divisor is even");

endmodule
`default_nettype wire

/* src/tdf_ctrl.sv */
`default_nettype none
module tdf_ctrl
    import tdf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_NOFAC,
        S_TWOS,
        S_START,
        S_WAIT,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
                state_next = stat.value_le1 ? S_NOFAC : S_TWOS;
            S_NOFAC:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_NOFAC;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TWOS:
            begin
                if (!stat.rem_even)
                    state_next = S_START;
                else if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_TWO;
                    cmd.emit_last = stat.rem_is_two;
                    cmd.shift     = 1'b1;
                    if (stat.rem_is_two)
                        state_next = S_IDLE;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.cand_gt_q)
                    state_next = S_EMIT;
                else if (stat.mod_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = SEL_CAND;
                        cmd.take_quot = 1'b1;
                        state_next    = S_START;
                    end
                end
                else
                begin
                    cmd.cand_inc = 1'b1;
                    state_next   = S_START;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_REM;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("item emitted into a full output register");

    a_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !cmd.emit && !cmd.div_start)
        else $error("activity right after divider start");

endmodule
`default_nettype wire

/* src/trial_division_factorizer.sv */
`default_nettype none
// Prime factorizer by trial division. Each accepted value is split into its
// prime factors, sent out in ascending order and repeated by multiplicity,
// one item per factor, with last_factor set on the final item of that value.
// Values 0 and 1 give one item with factor 0, status 1 and last_factor set.
// Factors of two are peeled off first; then odd trial divisors
// from 3 upward are tested by a restoring divider that produces one quotient
// bit per cycle, so every divisor tried goes through a start, the divide and
// a decision, and every odd factor found costs one more divide. A 32-bit
// prime tries about 32800 divisors and a 31-bit prime about 23200; a value
// built only from small factors needs far fewer.
// One value is worked on at a time; the next is taken once the last item of
// the current one sits in the output register, even while that item is
// still stalled.
module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [FIELD_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [FIELD_W-1:0]      factor,
    output logic                    last_factor,
    output logic                    status
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: input handshake, phase walk, emit decisions
    tdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // remainder, trial divisor, divider and output register
    tdf_dp #(.W(VALUE_WIDTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .factor      (factor),
        .last_factor (last_factor),
        .status      (status)
    );

endmodule
`default_nettype wire
